// ===== design/abkd_pkg.sv =====
// Shared types and constants for the anchor box and keypoint decoder.
`timescale 1ns / 1ps

package abkd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SCORE_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_GRID_WIDTH      = 3'd1;
    localparam logic [2:0] CFG_GRID_HEIGHT     = 3'd2;
    localparam logic [2:0] CFG_PAD_LEFT        = 3'd3;
    localparam logic [2:0] CFG_PAD_TOP         = 3'd4;
    localparam logic [2:0] CFG_INVERSE_SCALE   = 3'd5;
    localparam logic [2:0] CFG_USE_KEYPOINTS   = 3'd6;
    localparam logic [2:0] CFG_MAX_BOXES       = 3'd7;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [15:0] RST_SCORE_THRESHOLD = 16'd16384;
    localparam logic [11:0] RST_GRID_WIDTH      = 12'd640;
    localparam logic [11:0] RST_GRID_HEIGHT     = 12'd640;
    localparam logic [15:0] RST_PAD             = 16'd0;
    localparam logic [15:0] RST_INVERSE_SCALE   = 16'd4096;
    localparam logic        RST_USE_KEYPOINTS   = 1'b1;
    localparam logic [15:0] RST_MAX_BOXES       = 16'd4096;

    // Geometry: level 0 has stride 8, each level doubles it.
    localparam logic [3:0] BASE_SHIFT = 4'd3;
    localparam int LEVEL_W  = 3;   // covers up to eight stride levels
    localparam int COORD_W  = 10;  // grid column / row counter width
    localparam int KP_PORTS = 5;

    // Fixed-point output range, Q15.4.
    localparam int OUT_W = 20;
    localparam logic signed [28:0] OUT_MIN   = -29'sd524288;
    localparam logic signed [28:0] OUT_MAX   = 29'sd524287;
    localparam logic signed [44:0] ROUND_HALF = 45'sd32768;

    typedef struct packed {
        logic [15:0] score_threshold;
        logic [11:0] grid_width;
        logic [11:0] grid_height;
        logic [15:0] pad_left;
        logic [15:0] pad_top;
        logic [15:0] inverse_scale;
        logic        use_keypoints;
        logic [15:0] max_boxes;
    } t_cfg;

    // One kept anchor, with the grid position it was decoded at.
    typedef struct packed {
        logic [15:0]                score;
        logic [15:0]                dist_left;
        logic [15:0]                dist_top;
        logic [15:0]                dist_right;
        logic [15:0]                dist_bottom;
        logic [KP_PORTS-1:0][31:0]  kp_offset;
        logic [COORD_W-1:0]         column;
        logic [COORD_W-1:0]         row;
        logic [LEVEL_W-1:0]         level;
    } t_item;

endpackage

// ===== design/anchor_box_keypoint_decoder.sv =====
// Top level: anchor box and keypoint decoder with config registers.
// A kept item is written to the queue, then passes the coordinate lanes to the results.
// Throughput: one item per cycle unless the queue is full; set by the filter stage,
// the 3-stage lanes (a 28x17 multiply each) and pop. Dropped items give no result.
// Reset: synchronous active low; clears grid counters, box count, queue and result
// valid, and loads the register defaults. No clearing pass; ready right after reset.
`timescale 1ns / 1ps

module anchor_box_keypoint_decoder #(
    parameter int ANCHORS_PER_CELL = 2,
    parameter int STRIDE_LEVELS    = 3,
    parameter int KEYPOINTS        = 5,
    parameter int QUEUE_DEPTH      = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [abkd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [abkd_pkg::CFG_DATA_W-1:0] i_cfg_data,

    // Anchor items in.
    input  logic                push,
    output logic                full,
    input  logic [15:0]         i_score,
    input  logic signed [15:0]  i_dist_left,
    input  logic signed [15:0]  i_dist_top,
    input  logic signed [15:0]  i_dist_right,
    input  logic signed [15:0]  i_dist_bottom,
    input  logic [31:0]         i_kp_offset_0,
    input  logic [31:0]         i_kp_offset_1,
    input  logic [31:0]         i_kp_offset_2,
    input  logic [31:0]         i_kp_offset_3,
    input  logic [31:0]         i_kp_offset_4,

    // Decoded boxes out.
    output logic                empty,
    input  logic                pop,
    output logic signed [19:0]  o_box_x1,
    output logic signed [19:0]  o_box_y1,
    output logic signed [19:0]  o_box_x2,
    output logic signed [19:0]  o_box_y2,
    output logic [15:0]         o_box_score,
    output logic [39:0]         o_kp_pos_0,
    output logic [39:0]         o_kp_pos_1,
    output logic [39:0]         o_kp_pos_2,
    output logic [39:0]         o_kp_pos_3,
    output logic [39:0]         o_kp_pos_4
);

    abkd_pkg::t_cfg  r_cfg;
    abkd_pkg::t_item w_front_item, w_queue_item;
    logic            w_accept;
    logic            w_enq;
    logic            w_queue_valid;
    logic            w_queue_rd;
    logic            w_queue_full;
    logic [abkd_pkg::KP_PORTS-1:0][31:0] w_kp_offset;
    logic [abkd_pkg::KP_PORTS-1:0][39:0] w_kp_pos;

    // Configuration registers: write only while the block is idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.score_threshold <= abkd_pkg::RST_SCORE_THRESHOLD;
            r_cfg.grid_width      <= abkd_pkg::RST_GRID_WIDTH;
            r_cfg.grid_height     <= abkd_pkg::RST_GRID_HEIGHT;
            r_cfg.pad_left        <= abkd_pkg::RST_PAD;
            r_cfg.pad_top         <= abkd_pkg::RST_PAD;
            r_cfg.inverse_scale   <= abkd_pkg::RST_INVERSE_SCALE;
            r_cfg.use_keypoints   <= abkd_pkg::RST_USE_KEYPOINTS;
            r_cfg.max_boxes       <= abkd_pkg::RST_MAX_BOXES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                abkd_pkg::CFG_SCORE_THRESHOLD: r_cfg.score_threshold <= i_cfg_data;
                abkd_pkg::CFG_GRID_WIDTH:      r_cfg.grid_width      <= i_cfg_data[11:0];
                abkd_pkg::CFG_GRID_HEIGHT:     r_cfg.grid_height     <= i_cfg_data[11:0];
                abkd_pkg::CFG_PAD_LEFT:        r_cfg.pad_left        <= i_cfg_data;
                abkd_pkg::CFG_PAD_TOP:         r_cfg.pad_top         <= i_cfg_data;
                abkd_pkg::CFG_INVERSE_SCALE:   r_cfg.inverse_scale   <= i_cfg_data;
                abkd_pkg::CFG_USE_KEYPOINTS:   r_cfg.use_keypoints   <= i_cfg_data[0];
                abkd_pkg::CFG_MAX_BOXES:       r_cfg.max_boxes       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accept whenever the queue has room; filtered items advance counters only.
    assign full     = w_queue_full;
    assign w_accept = push && !w_queue_full;

    assign w_kp_offset[0] = i_kp_offset_0;
    assign w_kp_offset[1] = i_kp_offset_1;
    assign w_kp_offset[2] = i_kp_offset_2;
    assign w_kp_offset[3] = i_kp_offset_3;
    assign w_kp_offset[4] = i_kp_offset_4;

    abkd_front #(
        .ANCHORS_PER_CELL (ANCHORS_PER_CELL),
        .STRIDE_LEVELS    (STRIDE_LEVELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (w_accept),
        .i_score       (i_score),
        .i_dist_left   (i_dist_left),
        .i_dist_top    (i_dist_top),
        .i_dist_right  (i_dist_right),
        .i_dist_bottom (i_dist_bottom),
        .i_kp_offset   (w_kp_offset),
        .o_enq         (w_enq),
        .o_item        (w_front_item)
    );

    // Hold kept items until the decode lanes can take them.
    abkd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_enq),
        .i_data  (w_front_item),
        .i_rd    (w_queue_rd),
        .o_data  (w_queue_item),
        .o_valid (w_queue_valid),
        .o_full  (w_queue_full)
    );

    // Decode lanes; the last stage doubles as the result register.
    abkd_back #(
        .KEYPOINTS (KEYPOINTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (w_queue_item),
        .i_item_valid (w_queue_valid),
        .o_item_rd    (w_queue_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_box_x1     (o_box_x1),
        .o_box_y1     (o_box_y1),
        .o_box_x2     (o_box_x2),
        .o_box_y2     (o_box_y2),
        .o_box_score  (o_box_score),
        .o_kp_pos     (w_kp_pos)
    );

    assign o_kp_pos_0 = w_kp_pos[0];
    assign o_kp_pos_1 = w_kp_pos[1];
    assign o_kp_pos_2 = w_kp_pos[2];
    assign o_kp_pos_3 = w_kp_pos[3];
    assign o_kp_pos_4 = w_kp_pos[4];

endmodule

// ===== design/abkd_front.sv =====
// Front end: anchor/grid counters, score and box-limit filter.
`timescale 1ns / 1ps

module abkd_front #(
    parameter int ANCHORS_PER_CELL = 2,
    parameter int STRIDE_LEVELS    = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  abkd_pkg::t_cfg       i_cfg,
    input  logic                 i_accept,
    input  logic [15:0]          i_score,
    input  logic [15:0]          i_dist_left,
    input  logic [15:0]          i_dist_top,
    input  logic [15:0]          i_dist_right,
    input  logic [15:0]          i_dist_bottom,
    input  logic [abkd_pkg::KP_PORTS-1:0][31:0] i_kp_offset,
    output logic                 o_enq,
    output abkd_pkg::t_item      o_item
);

    localparam int AW = (ANCHORS_PER_CELL > 1) ? $clog2(ANCHORS_PER_CELL) : 1;
    localparam int LW = abkd_pkg::LEVEL_W;
    localparam int CW = abkd_pkg::COORD_W;

    logic [AW-1:0] r_anchor, n_anchor;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [LW-1:0] r_level, n_level;
    logic [15:0]   r_boxes, n_boxes;

    logic [3:0]  w_shamt;
    logic [11:0] w_cols, w_rows;
    logic        w_empty;
    logic [LW:0] w_next_level;
    logic        w_next_ok;
    logic        w_keep;
    logic        w_frame_end;

    always_comb begin
        w_shamt      = abkd_pkg::BASE_SHIFT + 4'(r_level);
        w_cols       = i_cfg.grid_width >> w_shamt;
        w_rows       = i_cfg.grid_height >> w_shamt;
        w_empty      = (w_cols == '0) || (w_rows == '0);
        w_next_level = {1'b0, r_level} + 1'b1;
        w_next_ok    = (w_next_level < (LW+1)'(STRIDE_LEVELS))
                    && ((i_cfg.grid_width >> (w_shamt + 4'd1)) != '0)
                    && ((i_cfg.grid_height >> (w_shamt + 4'd1)) != '0);
        w_keep       = (i_score >= i_cfg.score_threshold)
                    && (r_boxes < i_cfg.max_boxes);
    end

    // Walk anchors, then columns, rows and levels.
    always_comb begin
        n_anchor    = r_anchor;
        n_col       = r_col;
        n_row       = r_row;
        n_level     = r_level;
        w_frame_end = 1'b0;
        if (({1'b0, r_anchor} + 1'b1) < (AW+1)'(ANCHORS_PER_CELL)) begin
            n_anchor = r_anchor + 1'b1;
        end else begin
            n_anchor = '0;
            if (!w_empty && (({2'b0, r_col} + 12'd1) < w_cols)) begin
                n_col = r_col + 1'b1;
            end else begin
                n_col = '0;
                if (!w_empty && (({2'b0, r_row} + 12'd1) < w_rows)) begin
                    n_row = r_row + 1'b1;
                end else begin
                    n_row = '0;
                    if (w_next_ok) begin
                        n_level = w_next_level[LW-1:0];
                    end else begin
                        n_level     = '0;
                        w_frame_end = 1'b1;
                    end
                end
            end
        end
        if (w_frame_end) begin
            n_boxes = '0;
        end else if (w_keep) begin
            n_boxes = r_boxes + 16'd1;
        end else begin
            n_boxes = r_boxes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_level  <= '0;
            r_boxes  <= '0;
        end else if (i_accept) begin
            r_anchor <= n_anchor;
            r_col    <= n_col;
            r_row    <= n_row;
            r_level  <= n_level;
            r_boxes  <= n_boxes;
        end
    end

    assign o_enq = i_accept && w_keep;

    always_comb begin
        o_item.score       = i_score;
        o_item.dist_left   = i_dist_left;
        o_item.dist_top    = i_dist_top;
        o_item.dist_right  = i_dist_right;
        o_item.dist_bottom = i_dist_bottom;
        o_item.kp_offset   = i_kp_offset;
        o_item.column      = r_col;
        o_item.row         = r_row;
        o_item.level       = r_level;
    end

endmodule

// ===== design/abkd_queue.sv =====
// Short FIFO between the front filter and the decode pipeline.
`timescale 1ns / 1ps

module abkd_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  abkd_pkg::t_item i_data,
    input  logic            i_rd,
    output abkd_pkg::t_item o_data,
    output logic            o_valid,
    output logic            o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    abkd_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == NW'(DEPTH));

endmodule

// ===== design/abkd_coord.sv =====
// One coordinate lane: grid position to source pixels, three register stages.
`timescale 1ns / 1ps

module abkd_coord (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [abkd_pkg::COORD_W-1:0]        i_center,
    input  logic signed [16:0]                  i_off,
    input  logic [abkd_pkg::LEVEL_W-1:0]        i_level,
    input  logic [15:0]                         i_pad,
    input  logic [15:0]                         i_inv,
    output logic signed [abkd_pkg::OUT_W-1:0]   o_coord
);

    logic signed [19:0] w_pos;
    logic signed [27:0] w_pix;
    logic signed [27:0] w_pad;
    logic [3:0]         w_shamt;
    logic signed [44:0] w_a, w_b;
    logic signed [44:0] w_t;
    logic signed [28:0] w_q;

    logic signed [27:0] r_pix;
    logic [15:0]        r_inv;
    logic signed [44:0] r_prod;
    logic signed [abkd_pkg::OUT_W-1:0] r_coord;

    always_comb begin
        // Q.8 grid position, scaled by the stride, minus padding in Q.8.
        w_pos   = $signed({2'b00, i_center, 8'h00}) + {{3{i_off[16]}}, i_off};
        w_shamt = abkd_pkg::BASE_SHIFT + 4'(i_level);
        w_pad   = $signed({8'h00, i_pad, 4'h0});
        w_pix   = ({{8{w_pos[19]}}, w_pos} <<< w_shamt) - w_pad;

        w_a = {{17{r_pix[27]}}, r_pix};
        w_b = $signed({29'b0, r_inv});

        // Round half up, floor to Q.4, then saturate.
        w_t = r_prod + abkd_pkg::ROUND_HALF;
        w_q = 29'(w_t >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix  <= w_pix;
            r_inv  <= i_inv;
            r_prod <= w_a * w_b;
            if (w_q < abkd_pkg::OUT_MIN) begin
                r_coord <= abkd_pkg::OUT_MIN[abkd_pkg::OUT_W-1:0];
            end else if (w_q > abkd_pkg::OUT_MAX) begin
                r_coord <= abkd_pkg::OUT_MAX[abkd_pkg::OUT_W-1:0];
            end else begin
                r_coord <= w_q[abkd_pkg::OUT_W-1:0];
            end
        end
    end

    assign o_coord = r_coord;

endmodule

// ===== design/abkd_back.sv =====
// Back end: parallel coordinate lanes and the result register.
`timescale 1ns / 1ps

module abkd_back #(
    parameter int KEYPOINTS = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  abkd_pkg::t_cfg       i_cfg,
    input  abkd_pkg::t_item      i_item,
    input  logic                 i_item_valid,
    output logic                 o_item_rd,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic signed [abkd_pkg::OUT_W-1:0] o_box_x1,
    output logic signed [abkd_pkg::OUT_W-1:0] o_box_y1,
    output logic signed [abkd_pkg::OUT_W-1:0] o_box_x2,
    output logic signed [abkd_pkg::OUT_W-1:0] o_box_y2,
    output logic [15:0]          o_box_score,
    output logic [abkd_pkg::KP_PORTS-1:0][2*abkd_pkg::OUT_W-1:0] o_kp_pos
);

    localparam int OW = abkd_pkg::OUT_W;

    logic r_v1, r_v2, r_v3;
    logic [15:0] r_s1, r_s2, r_s3;
    logic w_en;

    logic signed [16:0] w_neg_left, w_neg_top, w_right, w_bottom;

    // Whole pipeline advances when the result slot is free or being taken.
    assign w_en      = !r_v3 || i_pop;
    assign o_item_rd = w_en && i_item_valid;
    assign o_empty   = !r_v3;

    always_comb begin
        w_neg_left = -$signed({i_item.dist_left[15], i_item.dist_left});
        w_neg_top  = -$signed({i_item.dist_top[15], i_item.dist_top});
        w_right    = $signed({i_item.dist_right[15], i_item.dist_right});
        w_bottom   = $signed({i_item.dist_bottom[15], i_item.dist_bottom});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_item_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= i_item.score;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    assign o_box_score = r_s3;

    abkd_coord u_x1 (
        .i_clk(i_clk), .i_en(w_en), .i_center(i_item.column), .i_off(w_neg_left),
        .i_level(i_item.level), .i_pad(i_cfg.pad_left), .i_inv(i_cfg.inverse_scale),
        .o_coord(o_box_x1)
    );
    abkd_coord u_y1 (
        .i_clk(i_clk), .i_en(w_en), .i_center(i_item.row), .i_off(w_neg_top),
        .i_level(i_item.level), .i_pad(i_cfg.pad_top), .i_inv(i_cfg.inverse_scale),
        .o_coord(o_box_y1)
    );
    abkd_coord u_x2 (
        .i_clk(i_clk), .i_en(w_en), .i_center(i_item.column), .i_off(w_right),
        .i_level(i_item.level), .i_pad(i_cfg.pad_left), .i_inv(i_cfg.inverse_scale),
        .o_coord(o_box_x2)
    );
    abkd_coord u_y2 (
        .i_clk(i_clk), .i_en(w_en), .i_center(i_item.row), .i_off(w_bottom),
        .i_level(i_item.level), .i_pad(i_cfg.pad_top), .i_inv(i_cfg.inverse_scale),
        .o_coord(o_box_y2)
    );

    for (genvar k = 0; k < abkd_pkg::KP_PORTS; k++) begin : g_kp
        if (k < KEYPOINTS) begin : g_lane
            logic signed [16:0]   w_off_x, w_off_y;
            logic signed [OW-1:0] w_x, w_y;

            assign w_off_x = $signed({i_item.kp_offset[k][15], i_item.kp_offset[k][15:0]});
            assign w_off_y = $signed({i_item.kp_offset[k][31], i_item.kp_offset[k][31:16]});

            abkd_coord u_kx (
                .i_clk(i_clk), .i_en(w_en), .i_center(i_item.column), .i_off(w_off_x),
                .i_level(i_item.level), .i_pad(i_cfg.pad_left),
                .i_inv(i_cfg.inverse_scale), .o_coord(w_x)
            );
            abkd_coord u_ky (
                .i_clk(i_clk), .i_en(w_en), .i_center(i_item.row), .i_off(w_off_y),
                .i_level(i_item.level), .i_pad(i_cfg.pad_top),
                .i_inv(i_cfg.inverse_scale), .o_coord(w_y)
            );

            // Zero the keypoints when keypoint decoding is off.
            assign o_kp_pos[k] = i_cfg.use_keypoints ? {w_y, w_x} : '0;
        end else begin : g_unused
            assign o_kp_pos[k] = '0;
        end
    end

endmodule

// ===== verif/anchor_box_keypoint_decoder_tb.sv =====
// Self-checking testbench for the anchor box and keypoint decoder.
`timescale 1ns / 1ps

module anchor_box_keypoint_decoder_tb;

    localparam int ANCHORS_PER_CELL = 2;
    localparam int STRIDE_LEVELS    = 3;
    localparam int KEYPOINTS        = 5;
    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 104;
    localparam int PRESSURE_PHASE   = 2;
    localparam int STEADY_PHASE     = 5;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES     = 8;
    localparam int IDLE_PERCENT     = 18;
    localparam int CYCLE_LIMIT      = 300000;

    // One detector output for one anchor.
    typedef struct packed {
        logic [15:0]                         score;
        logic signed [15:0]                  dist_left;
        logic signed [15:0]                  dist_top;
        logic signed [15:0]                  dist_right;
        logic signed [15:0]                  dist_bottom;
        logic [abkd_pkg::KP_PORTS-1:0][31:0] kp;
    } t_anchor;

    // One decoded box as it leaves the block.
    typedef struct packed {
        logic signed [19:0]                  x1;
        logic signed [19:0]                  y1;
        logic signed [19:0]                  x2;
        logic signed [19:0]                  y2;
        logic [15:0]                         score;
        logic [abkd_pkg::KP_PORTS-1:0][39:0] kp_pos;
    } t_box;

    // How a directed row gets its expected result.
    typedef enum {BY_PREDICTOR, TYPED_BOX, TYPED_DROP} t_row_kind;

    typedef struct {
        int        phase;
        t_row_kind kind;
        t_anchor   a;
        t_box      golden;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [abkd_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [abkd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        push          = 1'b0;
    logic        full;
    logic [15:0] i_score       = '0;
    logic signed [15:0] i_dist_left   = '0;
    logic signed [15:0] i_dist_top    = '0;
    logic signed [15:0] i_dist_right  = '0;
    logic signed [15:0] i_dist_bottom = '0;
    logic [31:0] i_kp_offset_0 = '0;
    logic [31:0] i_kp_offset_1 = '0;
    logic [31:0] i_kp_offset_2 = '0;
    logic [31:0] i_kp_offset_3 = '0;
    logic [31:0] i_kp_offset_4 = '0;
    logic        empty;
    logic        pop           = 1'b0;
    logic signed [19:0] o_box_x1, o_box_y1, o_box_x2, o_box_y2;
    logic [15:0] o_box_score;
    logic [39:0] o_kp_pos_0, o_kp_pos_1, o_kp_pos_2, o_kp_pos_3, o_kp_pos_4;

    // Predictor copy of the registers and the grid walk.
    abkd_pkg::t_cfg dec_cfg;
    int          pos_anchor, pos_col, pos_row, pos_level;
    logic [15:0] frame_boxes;

    t_box        pending_boxes[$];
    t_stim_row   directed_rows[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          gaps_on        = 1'b1;
    bit          stall_request  = 1'b0;

    anchor_box_keypoint_decoder #(
        .ANCHORS_PER_CELL(ANCHORS_PER_CELL),
        .STRIDE_LEVELS   (STRIDE_LEVELS),
        .KEYPOINTS       (KEYPOINTS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_score      (i_score),
        .i_dist_left  (i_dist_left),
        .i_dist_top   (i_dist_top),
        .i_dist_right (i_dist_right),
        .i_dist_bottom(i_dist_bottom),
        .i_kp_offset_0(i_kp_offset_0),
        .i_kp_offset_1(i_kp_offset_1),
        .i_kp_offset_2(i_kp_offset_2),
        .i_kp_offset_3(i_kp_offset_3),
        .i_kp_offset_4(i_kp_offset_4),
        .empty        (empty),
        .pop          (pop),
        .o_box_x1     (o_box_x1),
        .o_box_y1     (o_box_y1),
        .o_box_x2     (o_box_x2),
        .o_box_y2     (o_box_y2),
        .o_box_score  (o_box_score),
        .o_kp_pos_0   (o_kp_pos_0),
        .o_kp_pos_1   (o_kp_pos_1),
        .o_kp_pos_2   (o_kp_pos_2),
        .o_kp_pos_3   (o_kp_pos_3),
        .o_kp_pos_4   (o_kp_pos_4)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block wedges.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic abkd_pkg::t_cfg mk_cfg(input logic [15:0] thr, input logic [11:0] w,
                                              input logic [11:0] h, input logic [15:0] pl,
                                              input logic [15:0] pt, input logic [15:0] inv,
                                              input logic kp_on, input logic [15:0] mb);
        abkd_pkg::t_cfg c;
        c.score_threshold = thr;
        c.grid_width      = w;
        c.grid_height     = h;
        c.pad_left        = pl;
        c.pad_top         = pt;
        c.inverse_scale   = inv;
        c.use_keypoints   = kp_on;
        c.max_boxes       = mb;
        return c;
    endfunction

    // Grid center plus a Q8.8 offset, mapped to Q15.4 source pixels with
    // round-half-up and saturation.
    function automatic logic [19:0] to_source_px(input longint center, input longint off_q8,
                                                 input longint stride, input logic [15:0] pad);
        longint pos, pix, prod, q;
        pos  = center * 256 + off_q8;
        pix  = pos * stride - longint'(pad) * 16;
        prod = pix * longint'(dec_cfg.inverse_scale) + 32768;
        q    = prod >>> 16;                     // arithmetic shift floors negatives
        if (q < abkd_pkg::OUT_MIN) q = abkd_pkg::OUT_MIN;
        if (q > abkd_pkg::OUT_MAX) q = abkd_pkg::OUT_MAX;
        return q[19:0];
    endfunction

    // Advance anchor, column, row and level; wrap to a new frame after the
    // last non-empty level.
    function automatic void next_grid_position();
        int stride, cols, rows;
        bit level_empty;
        stride      = 8 << pos_level;
        cols        = int'(dec_cfg.grid_width) / stride;
        rows        = int'(dec_cfg.grid_height) / stride;
        level_empty = (cols == 0) || (rows == 0);
        pos_anchor++;
        if (pos_anchor < ANCHORS_PER_CELL) return;
        pos_anchor = 0;
        if (!level_empty && pos_col + 1 < cols) begin
            pos_col++;
            return;
        end
        pos_col = 0;
        if (!level_empty && pos_row + 1 < rows) begin
            pos_row++;
            return;
        end
        pos_row = 0;
        pos_level++;
        if (pos_level < STRIDE_LEVELS) begin
            stride = 8 << pos_level;
            if (int'(dec_cfg.grid_width) / stride != 0 &&
                int'(dec_cfg.grid_height) / stride != 0) return;
        end
        pos_level   = 0;
        frame_boxes = '0;
    endfunction

    // Decode one accepted anchor; returns 1 when it yields a box.
    function automatic bit decode_anchor(input t_anchor a, output t_box b);
        longint cx, cy, stride;
        logic [31:0] w;
        cx     = pos_col;
        cy     = pos_row;
        stride = longint'(8) << pos_level;
        b      = '0;
        if (a.score < dec_cfg.score_threshold || frame_boxes >= dec_cfg.max_boxes) begin
            next_grid_position();
            return 1'b0;
        end
        b.x1    = to_source_px(cx, -longint'($signed(a.dist_left)), stride, dec_cfg.pad_left);
        b.y1    = to_source_px(cy, -longint'($signed(a.dist_top)), stride, dec_cfg.pad_top);
        b.x2    = to_source_px(cx, longint'($signed(a.dist_right)), stride, dec_cfg.pad_left);
        b.y2    = to_source_px(cy, longint'($signed(a.dist_bottom)), stride, dec_cfg.pad_top);
        b.score = a.score;
        for (int k = 0; k < abkd_pkg::KP_PORTS; k++) begin
            if (dec_cfg.use_keypoints && k < KEYPOINTS) begin
                w = a.kp[k];
                b.kp_pos[k] = {to_source_px(cy, longint'($signed(w[31:16])), stride,
                                            dec_cfg.pad_top),
                               to_source_px(cx, longint'($signed(w[15:0])), stride,
                                            dec_cfg.pad_left)};
            end
        end
        frame_boxes = frame_boxes + 16'd1;
        next_grid_position();
        return 1'b1;
    endfunction

    function automatic t_anchor mk_anchor(input logic [15:0] score, input logic [15:0] dl,
                                          input logic [15:0] dt, input logic [15:0] dr,
                                          input logic [15:0] db, input logic [31:0] kp);
        t_anchor a;
        a.score       = score;
        a.dist_left   = dl;
        a.dist_top    = dt;
        a.dist_right  = dr;
        a.dist_bottom = db;
        for (int k = 0; k < abkd_pkg::KP_PORTS; k++) a.kp[k] = kp;
        return a;
    endfunction

    function automatic t_box mk_box(input logic signed [19:0] x1, input logic signed [19:0] y1,
                                    input logic signed [19:0] x2, input logic signed [19:0] y2,
                                    input logic [15:0] score, input logic [39:0] kp);
        t_box b;
        b.x1    = x1;
        b.y1    = y1;
        b.x2    = x2;
        b.y2    = y2;
        b.score = score;
        for (int k = 0; k < abkd_pkg::KP_PORTS; k++) b.kp_pos[k] = kp;
        return b;
    endfunction

    function automatic void add_row(input int phase, input t_row_kind kind, input t_anchor a,
                                    input t_box golden);
        t_stim_row r;
        r.phase  = phase;
        r.kind   = kind;
        r.a      = a;
        r.golden = golden;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // Half full-range noise, half small offsets within +/-4 grid units.
    function automatic logic [15:0] rand_q8();
        if ($urandom_range(0, 1) == 1) return 16'($urandom);
        return 16'($urandom_range(0, 2047) - 1024);
    endfunction

    function automatic t_anchor rand_anchor();
        t_anchor a;
        if ($urandom_range(0, 99) < 75)
            a.score = 16'($urandom_range(65535, dec_cfg.score_threshold));
        else
            a.score = 16'($urandom);
        a.dist_left   = rand_q8();
        a.dist_top    = rand_q8();
        a.dist_right  = rand_q8();
        a.dist_bottom = rand_q8();
        for (int k = 0; k < abkd_pkg::KP_PORTS; k++) a.kp[k] = {rand_q8(), rand_q8()};
        return a;
    endfunction

    // Random register set; small grids dominate so frames wrap often.
    function automatic abkd_pkg::t_cfg pick_setting();
        abkd_pkg::t_cfg c;
        case ($urandom_range(0, 3))
            0:       c.score_threshold = '0;
            1:       c.score_threshold = 16'($urandom);
            2:       c.score_threshold = 16'($urandom_range(0, 20000));
            default: c.score_threshold = 16'hFFFF;
        endcase
        case ($urandom_range(0, 5))
            0:       begin c.grid_width = 12'd640;  c.grid_height = 12'd640;  end
            1:       begin c.grid_width = 12'hFFF;  c.grid_height = 12'($urandom); end
            2:       begin c.grid_width = 12'($urandom); c.grid_height = 12'hFFF; end
            default: begin
                c.grid_width  = 12'($urandom_range(0, 96));
                c.grid_height = 12'($urandom_range(0, 96));
            end
        endcase
        c.pad_left  = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
        c.pad_top   = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
        case ($urandom_range(0, 3))
            0:       c.inverse_scale = 16'd4096;
            1:       c.inverse_scale = 16'hFFFF;
            default: c.inverse_scale = 16'($urandom_range(1, 65535));
        endcase
        c.use_keypoints = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       c.max_boxes = 16'($urandom_range(0, 6));
            1:       c.max_boxes = 16'hFFFF;
            2:       c.max_boxes = 16'($urandom);
            default: c.max_boxes = 16'd4096;
        endcase
        return c;
    endfunction

    // Drive one register write; the caller lowers the enable after the last one.
    task automatic put_reg(input logic [abkd_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic load_setting(input abkd_pkg::t_cfg s);
        put_reg(abkd_pkg::CFG_SCORE_THRESHOLD, s.score_threshold);
        put_reg(abkd_pkg::CFG_GRID_WIDTH,      16'(s.grid_width));
        put_reg(abkd_pkg::CFG_GRID_HEIGHT,     16'(s.grid_height));
        put_reg(abkd_pkg::CFG_PAD_LEFT,        s.pad_left);
        put_reg(abkd_pkg::CFG_PAD_TOP,         s.pad_top);
        put_reg(abkd_pkg::CFG_INVERSE_SCALE,   s.inverse_scale);
        put_reg(abkd_pkg::CFG_USE_KEYPOINTS,   16'(s.use_keypoints));
        put_reg(abkd_pkg::CFG_MAX_BOXES,       s.max_boxes);
        i_cfg_we <= 1'b0;
        dec_cfg = s;
    endtask

    // Drop push, wait for every pending box, then let dropped items clear
    // the pipeline before anything else happens.
    task automatic settle();
        push <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Offer one item, hold it until accepted, then record what it should yield.
    // Called at a rising edge; returns at the edge that accepted the item.
    task automatic send_anchor(input t_anchor a, input t_row_kind kind, input t_box golden);
        t_box predicted;
        bit   kept;
        while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_score       <= a.score;
        i_dist_left   <= a.dist_left;
        i_dist_top    <= a.dist_top;
        i_dist_right  <= a.dist_right;
        i_dist_bottom <= a.dist_bottom;
        i_kp_offset_0 <= a.kp[0];
        i_kp_offset_1 <= a.kp[1];
        i_kp_offset_2 <= a.kp[2];
        i_kp_offset_3 <= a.kp[3];
        i_kp_offset_4 <= a.kp[4];
        // Sample full mid-cycle, where it is stable, so the next edge is known to accept.
        @(negedge i_clk);
        while (full) @(negedge i_clk);
        @(posedge i_clk);
        kept = decode_anchor(a, predicted);
        case (kind)
            TYPED_BOX:  pending_boxes.insert(pending_boxes.size(), golden);
            TYPED_DROP: ;
            default:    if (kept) pending_boxes.insert(pending_boxes.size(), predicted);
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Receiver: random pop with idling, plus one long hold-off on request.
    initial begin : result_drain
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                hold_left     = HOLD_OFF_CYCLES;
                stall_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Compare every popped box against the oldest pending expectation.
    always @(posedge i_clk) begin
        t_box got, want;
        if (i_rst_n && pop && !empty) begin
            got.x1        = o_box_x1;
            got.y1        = o_box_y1;
            got.x2        = o_box_x2;
            got.y2        = o_box_y2;
            got.score     = o_box_score;
            got.kp_pos[0] = o_kp_pos_0;
            got.kp_pos[1] = o_kp_pos_1;
            got.kp_pos[2] = o_kp_pos_2;
            got.kp_pos[3] = o_kp_pos_3;
            got.kp_pos[4] = o_kp_pos_4;
            if (pending_boxes.size() == 0) begin
                report_mismatch("box with none pending, score", got.score, '0);
            end else begin
                want = pending_boxes.pop_front();
                if (got.x1 !== want.x1) report_mismatch("box_x1", got.x1, want.x1);
                if (got.y1 !== want.y1) report_mismatch("box_y1", got.y1, want.y1);
                if (got.x2 !== want.x2) report_mismatch("box_x2", got.x2, want.x2);
                if (got.y2 !== want.y2) report_mismatch("box_y2", got.y2, want.y2);
                if (got.score !== want.score)
                    report_mismatch("box_score", got.score, want.score);
                for (int k = 0; k < abkd_pkg::KP_PORTS; k++) begin
                    if (got.kp_pos[k] !== want.kp_pos[k])
                        report_mismatch($sformatf("kp_pos_%0d", k), got.kp_pos[k],
                                        want.kp_pos[k]);
                end
            end
        end
    end

    initial begin : stimulus
        abkd_pkg::t_cfg directed_setting[5];
        abkd_pkg::t_cfg s;
        int   cur_phase;

        dec_cfg = mk_cfg(abkd_pkg::RST_SCORE_THRESHOLD, abkd_pkg::RST_GRID_WIDTH,
                         abkd_pkg::RST_GRID_HEIGHT, abkd_pkg::RST_PAD, abkd_pkg::RST_PAD,
                         abkd_pkg::RST_INVERSE_SCALE, abkd_pkg::RST_USE_KEYPOINTS,
                         abkd_pkg::RST_MAX_BOXES);
        pos_anchor  = 0;
        pos_col     = 0;
        pos_row     = 0;
        pos_level   = 0;
        frame_boxes = '0;

        // Phase 0 runs on reset values; the rest are written before their rows.
        directed_setting[0] = dec_cfg;
        // zero inverse scale: every coordinate collapses to zero
        directed_setting[1] = mk_cfg(16'd0, 12'd640, 12'd640, 16'hFFFF, 16'hFFFF, 16'd0,
                                     1'b1, 16'hFFFF);
        // top threshold, largest scale and padding, keypoints off
        directed_setting[2] = mk_cfg(16'hFFFF, 12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF,
                                     16'hFFFF, 1'b0, 16'd4096);
        // empty grid: each cell is a frame of its own, one box allowed per frame
        directed_setting[3] = mk_cfg(16'd0, 12'd0, 12'd640, 16'd0, 16'd0, 16'd4096,
                                     1'b1, 16'd1);
        // box limit of zero: nothing comes out
        directed_setting[4] = mk_cfg(16'd0, 12'd64, 12'd64, 16'd0, 16'd0, 16'd4096,
                                     1'b1, 16'd0);

        // Reset defaults: stride 8 and unit scale, so a coordinate is pos_q8 / 2.
        add_row(0, TYPED_BOX,  mk_anchor(16'd16384, '0, '0, '0, '0, '0),
                mk_box('0, '0, '0, '0, 16'd16384, '0));
        add_row(0, TYPED_DROP, mk_anchor(16'd16383, 16'd5, 16'd5, 16'd5, 16'd5, 32'h0005_0005),
                '0);
        add_row(0, TYPED_BOX,  mk_anchor(16'hFFFF, 16'd256, 16'd256, 16'd256, 16'd256, '0),
                mk_box(20'sd0, -20'sd128, 20'sd256, 20'sd128, 16'hFFFF, 40'h80));
        add_row(0, BY_PREDICTOR, mk_anchor(16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                                           32'h7FFF_8000), '0);
        add_row(0, TYPED_DROP, mk_anchor(16'd0, '1, '1, '1, '1, '1), '0);
        add_row(0, BY_PREDICTOR, mk_anchor(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                                           32'h8000_7FFF), '0);
        add_row(0, BY_PREDICTOR, mk_anchor(16'h8000, 16'hFFFF, 16'h0001, 16'hFF00, 16'h0100,
                                           32'hFFFF_FFFF), '0);
        add_row(0, BY_PREDICTOR, mk_anchor(16'hC000, 16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0,
                                           32'h0001_FFFE), '0);

        add_row(1, TYPED_BOX, mk_anchor(16'd0, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, '1),
                mk_box('0, '0, '0, '0, 16'd0, '0));
        add_row(1, TYPED_BOX, mk_anchor(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                                        32'h8000_7FFF), mk_box('0, '0, '0, '0, 16'hFFFF, '0));
        add_row(1, TYPED_BOX, mk_anchor(16'h1234, 16'h0100, 16'hFF00, 16'h0200, 16'hFE00,
                                        32'h1234_5678), mk_box('0, '0, '0, '0, 16'h1234, '0));

        add_row(2, BY_PREDICTOR, mk_anchor(16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                                           32'h7FFF_7FFF), '0);
        add_row(2, TYPED_DROP, mk_anchor(16'hFFFE, '0, '0, '0, '0, '0), '0);
        add_row(2, BY_PREDICTOR, mk_anchor(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                                           32'h8000_8000), '0);

        add_row(3, BY_PREDICTOR, mk_anchor(16'd100, 16'h0080, 16'h0080, 16'h0180, 16'h0180,
                                           32'h0040_FFC0), '0);
        add_row(3, BY_PREDICTOR, mk_anchor(16'd200, 16'h0100, 16'h0100, 16'h0100, 16'h0100,
                                           32'h0000_0000), '0);
        add_row(3, BY_PREDICTOR, mk_anchor(16'd300, 16'hFF80, 16'h0200, 16'h0300, 16'hFE00,
                                           32'hFFC0_0040), '0);
        add_row(3, BY_PREDICTOR, mk_anchor(16'd400, 16'h0010, 16'h0020, 16'h0030, 16'h0040,
                                           32'h0101_0202), '0);

        add_row(4, TYPED_DROP, mk_anchor(16'hFFFF, '0, '0, '0, '0, '0), '0);
        add_row(4, TYPED_DROP, mk_anchor(16'hFFFF, 16'h0100, 16'h0100, 16'h0100, 16'h0100,
                                         '1), '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: switch register set whenever the phase changes.
        cur_phase = 0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].phase != cur_phase) begin
                settle();
                cur_phase = directed_rows[i].phase;
                load_setting(directed_setting[cur_phase]);
            end
            send_anchor(directed_rows[i].a, directed_rows[i].kind, directed_rows[i].golden);
        end

        // Random phases; counters carry over between phases, so a shrinking
        // grid also exercises the mid-frame wrap.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            s = pick_setting();
            if (ph == PRESSURE_PHASE) begin
                // keep everything so the output queue backs up during the hold-off
                s.score_threshold = '0;
                s.max_boxes       = '1;
            end
            gaps_on = (ph != STEADY_PHASE);
            load_setting(s);
            if (ph == PRESSURE_PHASE) stall_request = 1'b1;
            repeat (ITEMS_PER_PHASE) send_anchor(rand_anchor(), BY_PREDICTOR, '0);
        end

        settle();
        if (mismatch_count == 0 && pending_boxes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
